// ----- hdl/gsa_pkg.sv -----
package gsa_pkg;

    // Table geometry
    localparam int SLOTS   = 256;
    localparam int IDX_W   = 8;
    localparam int CNT_W   = 9;
    localparam int GEN_W   = 16;
    localparam int DATA_W  = 16;
    localparam int ACT_W   = 3;
    localparam int QDEPTH  = 2;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_CREATE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_GET    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CHECK  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

    // One queued command
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [DATA_W-1:0] definition_id;
        logic [DATA_W-1:0] stack_amount;
        logic [IDX_W-1:0]  handle_index;
        logic [GEN_W-1:0]  handle_generation;
        logic              handle_present;
    } cmd_t;

    // Queue to executor handshake
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_port_t;

    // Slot table word
    typedef struct packed {
        logic              occupied;
        logic [GEN_W-1:0]  generation;
        logic [DATA_W-1:0] definition;
        logic [DATA_W-1:0] stack;
    } slot_word_t;

    // Free list entry: index plus the generation it will be reissued with
    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [GEN_W-1:0] generation;
    } free_entry_t;

endpackage

// ----- hdl/gsa_front.sv -----
// Command intake: two-entry queue in front of the executor.
module gsa_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  gsa_pkg::cmd_t     push_cmd,
    output logic              full,
    output gsa_pkg::cmd_port_t head,
    input  logic              pop
);

    gsa_pkg::cmd_t entry_reg [gsa_pkg::QDEPTH];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    logic do_push, do_pop;

    assign full    = (count_reg == 2'(gsa_pkg::QDEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (do_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hdl/gsa_back.sv -----
// Executor: slot table and free list; it takes a new command only after finishing the last one.
module gsa_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  gsa_pkg::cmd_port_t          head,
    output logic                        pop,
    output logic                        done,
    output logic                        ok,
    output logic [gsa_pkg::IDX_W-1:0]   out_index,
    output logic [gsa_pkg::GEN_W-1:0]   out_generation,
    output logic [gsa_pkg::DATA_W-1:0]  out_definition,
    output logic [gsa_pkg::DATA_W-1:0]  out_stack,
    output logic [gsa_pkg::CNT_W-1:0]   active_count,
    output logic [gsa_pkg::CNT_W-1:0]   capacity
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // Memories
    gsa_pkg::slot_word_t  slot_mem [gsa_pkg::SLOTS];
    gsa_pkg::free_entry_t free_mem [gsa_pkg::SLOTS];

    logic state_reg, state_next;
    logic [gsa_pkg::CNT_W-1:0] slot_count_reg, slot_count_next;
    logic [gsa_pkg::CNT_W-1:0] free_count_reg, free_count_next;

    gsa_pkg::cmd_t        cur_reg;
    gsa_pkg::slot_word_t  slot_rd_reg;
    gsa_pkg::free_entry_t free_rd_reg;

    logic                       slot_we;
    logic [gsa_pkg::IDX_W-1:0]  slot_wa;
    gsa_pkg::slot_word_t        slot_wd;
    logic                       free_we;
    logic [gsa_pkg::IDX_W-1:0]  free_wa;
    gsa_pkg::free_entry_t       free_wd;
    logic [gsa_pkg::IDX_W-1:0]  free_ra;

    logic                        done_next, ok_next;
    logic [gsa_pkg::IDX_W-1:0]   oidx_next;
    logic [gsa_pkg::GEN_W-1:0]   ogen_next;
    logic [gsa_pkg::DATA_W-1:0]  odef_next, ostk_next;
    logic                        handle_valid;
    logic [gsa_pkg::GEN_W-1:0]   gen_inc;

    logic                        done_reg, ok_reg;
    logic [gsa_pkg::IDX_W-1:0]   oidx_reg;
    logic [gsa_pkg::GEN_W-1:0]   ogen_reg;
    logic [gsa_pkg::DATA_W-1:0]  odef_reg, ostk_reg;
    logic [gsa_pkg::CNT_W-1:0]   active_reg, capacity_reg;

    assign pop     = (state_reg == ST_IDLE) && head.valid;
    assign free_ra = gsa_pkg::IDX_W'(free_count_reg - gsa_pkg::CNT_W'(1));

    // Handle validation against the slot word read last cycle
    assign handle_valid = cur_reg.handle_present
                       && ({1'b0, cur_reg.handle_index} < slot_count_reg)
                       && slot_rd_reg.occupied
                       && (slot_rd_reg.generation == cur_reg.handle_generation);
    assign gen_inc = slot_rd_reg.generation + gsa_pkg::GEN_W'(1);

    // Command execution
    always_comb
    begin
        state_next      = state_reg;
        slot_count_next = slot_count_reg;
        free_count_next = free_count_reg;
        slot_we   = 1'b0;
        slot_wa   = cur_reg.handle_index;
        slot_wd   = '0;
        free_we   = 1'b0;
        free_wa   = gsa_pkg::IDX_W'(free_count_reg);
        free_wd   = '0;
        done_next = 1'b0;
        ok_next   = 1'b0;
        oidx_next = '0;
        ogen_next = '0;
        odef_next = '0;
        ostk_next = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                unique case (cur_reg.action)
                    gsa_pkg::ACT_CREATE:
                    begin
                        if (cur_reg.definition_id != '0)
                        begin
                            if (free_count_reg != '0)
                            begin
                                free_count_next = free_count_reg - gsa_pkg::CNT_W'(1);
                                slot_we   = 1'b1;
                                slot_wa   = free_rd_reg.index;
                                ok_next   = 1'b1;
                                oidx_next = free_rd_reg.index;
                                ogen_next = free_rd_reg.generation;
                            end
                            else if (slot_count_reg != gsa_pkg::CNT_W'(gsa_pkg::SLOTS))
                            begin
                                slot_count_next = slot_count_reg + gsa_pkg::CNT_W'(1);
                                slot_we   = 1'b1;
                                slot_wa   = gsa_pkg::IDX_W'(slot_count_reg);
                                ok_next   = 1'b1;
                                oidx_next = gsa_pkg::IDX_W'(slot_count_reg);
                                ogen_next = '0;
                            end
                            slot_wd.occupied   = 1'b1;
                            slot_wd.generation = ogen_next;
                            slot_wd.definition = cur_reg.definition_id;
                            slot_wd.stack      = cur_reg.stack_amount;
                        end
                    end
                    gsa_pkg::ACT_GET:
                    begin
                        if (handle_valid)
                        begin
                            ok_next   = 1'b1;
                            odef_next = slot_rd_reg.definition;
                            ostk_next = slot_rd_reg.stack;
                        end
                    end
                    gsa_pkg::ACT_REMOVE:
                    begin
                        if (handle_valid)
                        begin
                            ok_next            = 1'b1;
                            slot_we            = 1'b1;
                            slot_wd.generation = gen_inc;
                            if (free_count_reg != gsa_pkg::CNT_W'(gsa_pkg::SLOTS))
                            begin
                                free_we            = 1'b1;
                                free_wd.index      = cur_reg.handle_index;
                                free_wd.generation = gen_inc;
                                free_count_next    = free_count_reg + gsa_pkg::CNT_W'(1);
                            end
                        end
                    end
                    gsa_pkg::ACT_CHECK:
                    begin
                        ok_next = handle_valid;
                    end
                    gsa_pkg::ACT_CLEAR:
                    begin
                        ok_next         = 1'b1;
                        slot_count_next = '0;
                        free_count_next = '0;
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_count_reg <= '0;
            free_count_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_count_reg <= slot_count_next;
            free_count_reg <= free_count_next;
            done_reg       <= done_next;
        end
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head.cmd;
        end
        ok_reg       <= ok_next;
        oidx_reg     <= oidx_next;
        ogen_reg     <= ogen_next;
        odef_reg     <= odef_next;
        ostk_reg     <= ostk_next;
        active_reg   <= slot_count_next - free_count_next;
        capacity_reg <= slot_count_next;
    end

    // Slot table: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_rd_reg <= slot_mem[head.cmd.handle_index];
    end

    // Free list: one write, one registered read at the top of stack
    always_ff @(posedge clk)
    begin
        if (free_we)
        begin
            free_mem[free_wa] <= free_wd;
        end
        free_rd_reg <= free_mem[free_ra];
    end

    assign done           = done_reg;
    assign ok             = ok_reg;
    assign out_index      = oidx_reg;
    assign out_generation = ogen_reg;
    assign out_definition = odef_reg;
    assign out_stack      = ostk_reg;
    assign active_count   = active_reg;
    assign capacity       = capacity_reg;

endmodule

// ----- hdl/generational_slot_allocator.sv -----
// Generational slot allocator. Issue a transaction by raising start while busy
// is low; it enters a two-entry command queue, and busy rises only when that
// queue is full. The executor takes a new transaction only after finishing the
// last one: it pops the queue head while idle, registering the reads of the
// slot table and free list, then updates them and registers the result. Each
// result is shown for exactly one cycle with done high and cannot be held off:
// the receiver must take it in that cycle. Results come back in issue order,
// one per transaction. Fields not set by an action read as zero.
module generational_slot_allocator
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [gsa_pkg::ACT_W-1:0]   action,
    input  logic [gsa_pkg::DATA_W-1:0]  definition_id,
    input  logic [gsa_pkg::DATA_W-1:0]  stack_amount,
    input  logic [gsa_pkg::IDX_W-1:0]   handle_index,
    input  logic [gsa_pkg::GEN_W-1:0]   handle_generation,
    input  logic                        handle_present,
    output logic                        done,
    output logic                        ok,
    output logic [gsa_pkg::IDX_W-1:0]   out_index,
    output logic [gsa_pkg::GEN_W-1:0]   out_generation,
    output logic [gsa_pkg::DATA_W-1:0]  out_definition,
    output logic [gsa_pkg::DATA_W-1:0]  out_stack,
    output logic [gsa_pkg::CNT_W-1:0]   active_count,
    output logic [gsa_pkg::CNT_W-1:0]   capacity
);

    gsa_pkg::cmd_t      in_cmd;
    gsa_pkg::cmd_port_t head;
    logic               pop;

    // Pack the incoming transaction
    assign in_cmd.action            = action;
    assign in_cmd.definition_id     = definition_id;
    assign in_cmd.stack_amount      = stack_amount;
    assign in_cmd.handle_index      = handle_index;
    assign in_cmd.handle_generation = handle_generation;
    assign in_cmd.handle_present    = handle_present;

    gsa_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (start),
        .push_cmd (in_cmd),
        .full     (busy),
        .head     (head),
        .pop      (pop)
    );

    gsa_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .pop            (pop),
        .done           (done),
        .ok             (ok),
        .out_index      (out_index),
        .out_generation (out_generation),
        .out_definition (out_definition),
        .out_stack      (out_stack),
        .active_count   (active_count),
        .capacity       (capacity)
    );

endmodule

// ----- bench/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One result transaction as seen on the output ports
    typedef struct packed {
        logic                       ok;
        logic [gsa_pkg::IDX_W-1:0]  index;
        logic [gsa_pkg::GEN_W-1:0]  generation;
        logic [gsa_pkg::DATA_W-1:0] definition;
        logic [gsa_pkg::DATA_W-1:0] stack_size;
        logic [gsa_pkg::CNT_W-1:0]  active;
        logic [gsa_pkg::CNT_W-1:0]  capacity;
    } alloc_result_t;

    // Actions 5..7 are undecoded
    localparam logic [gsa_pkg::ACT_W-1:0] ACT_UNUSED_FIRST =
        gsa_pkg::ACT_CLEAR + gsa_pkg::ACT_W'(1);

    // Slot map mirror and in-order result queue
    class slot_table_scoreboard;
        logic [gsa_pkg::DATA_W-1:0] definition [gsa_pkg::SLOTS];
        logic [gsa_pkg::DATA_W-1:0] stack_size [gsa_pkg::SLOTS];
        logic [gsa_pkg::GEN_W-1:0]  generation [gsa_pkg::SLOTS];
        bit                         occupied   [gsa_pkg::SLOTS];
        int                         free_list  [gsa_pkg::SLOTS];
        int                         free_count = 0;
        int                         slot_count = 0;
        alloc_result_t              pending_results [$];
        int failures = 0;
        int results_checked = 0;
        int creates_ok = 0;
        int null_rejects = 0;
        int full_rejects = 0;
        int handles_good = 0;
        int handles_bad = 0;
        int clears = 0;

        function bit handle_valid(logic [gsa_pkg::IDX_W-1:0] idx,
                                  logic [gsa_pkg::GEN_W-1:0] gen, logic pres);
            return pres && (int'(idx) < slot_count) && occupied[idx]
                && (generation[idx] == gen);
        endfunction

        // Apply one accepted command and queue the result it must produce
        function void note_command(logic [gsa_pkg::ACT_W-1:0] act,
                                   logic [gsa_pkg::DATA_W-1:0] def,
                                   logic [gsa_pkg::DATA_W-1:0] amt,
                                   logic [gsa_pkg::IDX_W-1:0] idx,
                                   logic [gsa_pkg::GEN_W-1:0] gen, logic pres);
            alloc_result_t r;
            int slot;
            bit valid;
            r = '0;
            slot = -1;
            valid = handle_valid(idx, gen, pres);
            case (act) inside
                gsa_pkg::ACT_CREATE:
                begin
                    if (def == '0)
                        null_rejects++;
                    else if (free_count > 0)
                    begin
                        free_count--;
                        slot = free_list[free_count];
                    end
                    else if (slot_count < gsa_pkg::SLOTS)
                    begin
                        slot = slot_count;
                        slot_count++;
                        generation[slot] = '0;
                    end
                    else
                        full_rejects++;
                    if (slot >= 0)
                    begin
                        definition[slot] = def;
                        stack_size[slot] = amt;
                        occupied[slot]   = 1'b1;
                        r.ok         = 1'b1;
                        r.index      = slot[gsa_pkg::IDX_W-1:0];
                        r.generation = generation[slot];
                        creates_ok++;
                    end
                end
                gsa_pkg::ACT_GET, gsa_pkg::ACT_REMOVE, gsa_pkg::ACT_CHECK:
                begin
                    r.ok = valid;
                    if (valid)
                        handles_good++;
                    else
                        handles_bad++;
                    if (valid && act == gsa_pkg::ACT_GET)
                    begin
                        r.definition = definition[idx];
                        r.stack_size = stack_size[idx];
                    end
                    if (valid && act == gsa_pkg::ACT_REMOVE)
                    begin
                        definition[idx] = '0;
                        stack_size[idx] = '0;
                        occupied[idx]   = 1'b0;
                        if (free_count < gsa_pkg::SLOTS)
                        begin
                            free_list[free_count] = int'(idx);
                            free_count++;
                        end
                        generation[idx] = generation[idx] + gsa_pkg::GEN_W'(1);
                    end
                end
                gsa_pkg::ACT_CLEAR:
                begin
                    slot_count = 0;
                    free_count = 0;
                    r.ok = 1'b1;
                    clears++;
                end
                default: ;
            endcase
            r.active   = gsa_pkg::CNT_W'(slot_count - free_count);
            r.capacity = gsa_pkg::CNT_W'(slot_count);
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("%0t ns mismatch: %s", $time, what);
            failures++;
        endtask

        // Compare a result transaction with the oldest outstanding one
        task check_result(alloc_result_t got);
            alloc_result_t want;
            if (pending_results.size() == 0)
                report_mismatch("result with no transaction outstanding");
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.ok !== want.ok)
                    report_mismatch($sformatf("ok %b, want %b", got.ok, want.ok));
                if (got.index !== want.index)
                    report_mismatch($sformatf("out_index %0d, want %0d",
                                              got.index, want.index));
                if (got.generation !== want.generation)
                    report_mismatch($sformatf("out_generation %0d, want %0d",
                                              got.generation, want.generation));
                if (got.definition !== want.definition)
                    report_mismatch($sformatf("out_definition %0d, want %0d",
                                              got.definition, want.definition));
                if (got.stack_size !== want.stack_size)
                    report_mismatch($sformatf("out_stack %0d, want %0d",
                                              got.stack_size, want.stack_size));
                if (got.active !== want.active)
                    report_mismatch($sformatf("active_count %0d, want %0d",
                                              got.active, want.active));
                if (got.capacity !== want.capacity)
                    report_mismatch($sformatf("capacity %0d, want %0d",
                                              got.capacity, want.capacity));
            end
        endtask
    endclass

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [gsa_pkg::ACT_W-1:0]  action = '0;
    logic [gsa_pkg::DATA_W-1:0] definition_id = '0;
    logic [gsa_pkg::DATA_W-1:0] stack_amount = '0;
    logic [gsa_pkg::IDX_W-1:0]  handle_index = '0;
    logic [gsa_pkg::GEN_W-1:0]  handle_generation = '0;
    logic                       handle_present = 1'b0;
    logic                       done;
    logic                       ok;
    logic [gsa_pkg::IDX_W-1:0]  out_index;
    logic [gsa_pkg::GEN_W-1:0]  out_generation;
    logic [gsa_pkg::DATA_W-1:0] out_definition;
    logic [gsa_pkg::DATA_W-1:0] out_stack;
    logic [gsa_pkg::CNT_W-1:0]  active_count;
    logic [gsa_pkg::CNT_W-1:0]  capacity;

    slot_table_scoreboard sb;
    alloc_result_t        seen_result;
    bit                   steady = 1'b0;

    generational_slot_allocator DUT
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .action            (action),
        .definition_id     (definition_id),
        .stack_amount      (stack_amount),
        .handle_index      (handle_index),
        .handle_generation (handle_generation),
        .handle_present    (handle_present),
        .done              (done),
        .ok                (ok),
        .out_index         (out_index),
        .out_generation    (out_generation),
        .out_definition    (out_definition),
        .out_stack         (out_stack),
        .active_count      (active_count),
        .capacity          (capacity)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result monitor: every strobed result is taken in its one cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen_result.ok         = ok;
            seen_result.index      = out_index;
            seen_result.generation = out_generation;
            seen_result.definition = out_definition;
            seen_result.stack_size = out_stack;
            seen_result.active     = active_count;
            seen_result.capacity   = capacity;
            sb.check_result(seen_result);
        end
    end

    // Hold one command until accepted, then maybe leave a gap with junk on the bus
    task automatic issue(input logic [gsa_pkg::ACT_W-1:0] act,
                         input logic [gsa_pkg::DATA_W-1:0] def,
                         input logic [gsa_pkg::DATA_W-1:0] amt,
                         input logic [gsa_pkg::IDX_W-1:0] idx,
                         input logic [gsa_pkg::GEN_W-1:0] gen, input logic pres);
        action            <= act;
        definition_id     <= def;
        stack_amount      <= amt;
        handle_index      <= idx;
        handle_generation <= gen;
        handle_present    <= pres;
        start             <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(act, def, amt, idx, gen, pres);
        @(negedge clk);
        if (!steady && $urandom_range(99) < 24)
        begin
            start             <= 1'b0;
            action            <= gsa_pkg::ACT_W'($urandom);
            definition_id     <= gsa_pkg::DATA_W'($urandom);
            handle_index      <= gsa_pkg::IDX_W'($urandom);
            handle_generation <= gsa_pkg::GEN_W'($urandom);
            handle_present    <= 1'b1;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
    endtask

    // Stimulus
    initial
    begin
        int sc;
        int pick;
        logic [gsa_pkg::ACT_W-1:0]  act;
        logic [gsa_pkg::DATA_W-1:0] def;
        logic [gsa_pkg::IDX_W-1:0]  idx;
        logic [gsa_pkg::GEN_W-1:0]  gen;
        logic                       pres;

        sb = new();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: field extremes, bad handles, LIFO reuse, undecoded actions, clear
        issue(gsa_pkg::ACT_CREATE, 16'h0000, 16'h1234, 8'h00, 16'h0000, 1'b0);
        issue(gsa_pkg::ACT_CREATE, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1);
        issue(gsa_pkg::ACT_CREATE, 16'h0001, 16'h0000, 8'h00, 16'h0000, 1'b0);
        issue(gsa_pkg::ACT_GET,    16'hFFFF, 16'hFFFF, 8'h00, 16'h0000, 1'b1);
        issue(gsa_pkg::ACT_GET,    16'h0000, 16'h0000, 8'h00, 16'h0001, 1'b1);
        issue(gsa_pkg::ACT_GET,    16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b0);
        issue(gsa_pkg::ACT_GET,    16'h0000, 16'h0000, 8'h02, 16'h0000, 1'b1);
        issue(gsa_pkg::ACT_GET,    16'h0000, 16'h0000, 8'hFF, 16'hFFFF, 1'b1);
        issue(gsa_pkg::ACT_CHECK,  16'h0000, 16'h0000, 8'h01, 16'h0000, 1'b1);
        issue(gsa_pkg::ACT_REMOVE, 16'h0000, 16'h0000, 8'h01, 16'h0000, 1'b1);
        issue(gsa_pkg::ACT_REMOVE, 16'h0000, 16'h0000, 8'h01, 16'h0000, 1'b1);
        issue(gsa_pkg::ACT_CHECK,  16'h0000, 16'h0000, 8'h01, 16'h0000, 1'b1);
        issue(gsa_pkg::ACT_GET,    16'h0000, 16'h0000, 8'h01, 16'h0001, 1'b1);
        issue(gsa_pkg::ACT_CREATE, 16'h0007, 16'h0009, 8'h00, 16'h0000, 1'b0);
        issue(gsa_pkg::ACT_GET,    16'h0000, 16'h0000, 8'h01, 16'h0001, 1'b1);
        issue(gsa_pkg::ACT_REMOVE, 16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1);
        issue(gsa_pkg::ACT_REMOVE, 16'h0000, 16'h0000, 8'h01, 16'h0001, 1'b1);
        issue(gsa_pkg::ACT_CREATE, 16'h8000, 16'h8000, 8'h00, 16'h0000, 1'b0);
        issue(gsa_pkg::ACT_CREATE, 16'h00FF, 16'h7FFF, 8'h00, 16'h0000, 1'b0);
        for (int a = 0; a < 3; a++)
            issue(ACT_UNUSED_FIRST + gsa_pkg::ACT_W'(a), 16'hFFFF, 16'hFFFF, 8'h00,
                  16'h0001, 1'b1);
        issue(gsa_pkg::ACT_CLEAR,  16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1);
        issue(gsa_pkg::ACT_GET,    16'h0000, 16'h0000, 8'h00, 16'h0001, 1'b1);
        issue(gsa_pkg::ACT_CREATE, 16'h0042, 16'h0001, 8'h00, 16'h0000, 1'b0);

        // Fill every slot, hit the full table, then reuse freed slots in LIFO order
        issue(gsa_pkg::ACT_CLEAR, '0, '0, '0, '0, 1'b0);
        for (int i = 0; i <= gsa_pkg::SLOTS; i++)
            issue(gsa_pkg::ACT_CREATE, gsa_pkg::DATA_W'($urandom_range(65535, 1)),
                  gsa_pkg::DATA_W'($urandom), gsa_pkg::IDX_W'($urandom),
                  gsa_pkg::GEN_W'($urandom), 1'($urandom));
        issue(gsa_pkg::ACT_CREATE, 16'h0000, gsa_pkg::DATA_W'($urandom), '0, '0, 1'b0);
        issue(gsa_pkg::ACT_REMOVE, '0, '0, 8'd200, sb.generation[200], 1'b1);
        issue(gsa_pkg::ACT_REMOVE, '0, '0, 8'd17, sb.generation[17], 1'b1);
        for (int i = 0; i < 3; i++)
            issue(gsa_pkg::ACT_CREATE, gsa_pkg::DATA_W'($urandom_range(65535, 1)),
                  gsa_pkg::DATA_W'($urandom), '0, '0, 1'b0);
        issue(gsa_pkg::ACT_GET, '0, '0, 8'd255, sb.generation[255], 1'b1);

        // Random: mostly live handles, some stale, absent, out of range or junk
        for (int n = 0; n < 1660; n++)
        begin
            steady = (n >= 800 && n < 1100);
            sc   = sb.slot_count;
            def  = gsa_pkg::DATA_W'($urandom);
            idx  = gsa_pkg::IDX_W'($urandom);
            gen  = gsa_pkg::GEN_W'($urandom);
            pres = 1'($urandom);
            pick = int'($urandom_range(99));
            if (pick < 38)
            begin
                act = gsa_pkg::ACT_CREATE;
                def = gsa_pkg::DATA_W'($urandom_range(65535, 1));
            end
            else if (pick < 41)
            begin
                act = gsa_pkg::ACT_CREATE;
                def = '0;
            end
            else if (pick < 60)
                act = gsa_pkg::ACT_GET;
            else if (pick < 80)
                act = gsa_pkg::ACT_REMOVE;
            else if (pick < 95)
                act = gsa_pkg::ACT_CHECK;
            else if (pick < 96)
                act = gsa_pkg::ACT_CLEAR;
            else
                act = ACT_UNUSED_FIRST + gsa_pkg::ACT_W'($urandom_range(2));

            if (act == gsa_pkg::ACT_GET || act == gsa_pkg::ACT_REMOVE
                || act == gsa_pkg::ACT_CHECK)
            begin
                pick = int'($urandom_range(99));
                pres = 1'b1;
                if (sc == 0 || pick < 8)
                    idx = (sc >= gsa_pkg::SLOTS) ? gsa_pkg::IDX_W'($urandom)
                        : gsa_pkg::IDX_W'($urandom_range(gsa_pkg::SLOTS - 1, sc));
                else if (pick < 95)
                begin
                    // prefer an occupied slot
                    idx = gsa_pkg::IDX_W'($urandom_range(sc - 1));
                    for (int t = 0; t < 4 && !sb.occupied[idx]; t++)
                        idx = gsa_pkg::IDX_W'($urandom_range(sc - 1));
                    gen = sb.generation[idx];
                    if (pick < 20)
                        gen = gen ^ (gsa_pkg::GEN_W'(1) << $urandom_range(gsa_pkg::GEN_W - 1));
                    else if (pick < 28)
                        pres = 1'b0;
                end
            end
            issue(act, def, gsa_pkg::DATA_W'($urandom), idx, gen, pres);
        end

        // Drain and allow for a stray late result
        start <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Checked %0d results: %0d creates, %0d null and %0d full rejections, %0d clears",
                 sb.results_checked, sb.creates_ok, sb.null_rejects, sb.full_rejects, sb.clears);
        $display("Handle lookups: %0d valid, %0d rejected",
                 sb.handles_good, sb.handles_bad);
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #60_000_000;
        $display("Timeout: run did not finish");
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- generational_slot_allocator.f -----
hdl/gsa_pkg.sv
hdl/gsa_front.sv
hdl/gsa_back.sv
hdl/generational_slot_allocator.sv
bench/tb.sv
